// ===== rtl/smi_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smi_pkg: shared definitions for the servo motion interpolator
// Transaction types, field widths, limits, state encodings and the reset
// pulse widths of the servo channels.
// ----------------------------------------------------------------------------
package smi_pkg;

	localparam int CHANNELS_DEF = 8;
	localparam int OUT_DUTIES   = 8;

	localparam int WIDTH_W = 12;
	localparam int STEPS_W = 11;
	localparam int PROD_W  = 2 * STEPS_W;
	localparam int CNT_W   = $clog2(STEPS_W);

	localparam logic [15:0] PULSE_MIN = 16'd500;
	localparam logic [15:0] PULSE_MAX = 16'd2500;
	localparam logic [15:0] TIME_MIN  = 16'd20;
	localparam logic [15:0] TIME_MAX  = 16'd30000;

	// 13108 / 65536 is just above one fifth; exact for quotients up to 7500.
	localparam logic [13:0] RECIP_FIVE = 14'd13108;

	// Step count of the reset move time of 2000 ms.
	localparam logic [STEPS_W-1:0] RESET_STEPS = 11'd100;

	typedef enum logic [1:0] {
		ACT_SET   = 2'd0,
		ACT_NUDGE = 2'd1,
		ACT_TICK  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_START,
		S_WAIT,
		S_FIN
	} ctl_state_t;

	typedef enum logic [1:0] {
		M_IDLE,
		M_MUL,
		M_DIV
	} md_state_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [2:0]  channel;
		logic [15:0] pulse;
		logic [15:0] move_time;
		logic        direction;
		logic [7:0]  step;
	} cmd_t;

	typedef struct packed {
		logic [WIDTH_W-1:0] duty_0;
		logic [WIDTH_W-1:0] duty_1;
		logic [WIDTH_W-1:0] duty_2;
		logic [WIDTH_W-1:0] duty_3;
		logic [WIDTH_W-1:0] duty_4;
		logic [WIDTH_W-1:0] duty_5;
		logic [WIDTH_W-1:0] duty_6;
		logic [WIDTH_W-1:0] duty_7;
		logic               moving;
		logic               accepted;
	} rsp_t;

	function automatic logic [WIDTH_W-1:0] reset_width(input int unsigned ch);
		logic [WIDTH_W-1:0] w;
		unique case (ch)
			3:       w = 12'd1050;
			4:       w = 12'd1000;
			5:       w = 12'd1700;
			default: w = 12'd1500;
		endcase
		return w;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/smi_muldiv.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smi_muldiv: bit-serial multiply then divide
// Computes floor(mag * k / divisor) one bit per cycle: eleven shift-add
// multiply steps followed by eleven restoring divide steps in one register.
// ----------------------------------------------------------------------------
module smi_muldiv (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [smi_pkg::STEPS_W-1:0] mag,
	input  logic [smi_pkg::STEPS_W-1:0] k,
	input  logic [smi_pkg::STEPS_W-1:0] divisor,
	output logic                        done,
	output logic [smi_pkg::STEPS_W-1:0] quo
);
	import smi_pkg::*;

	md_state_t          state_q;
	md_state_t          state_d;
	logic [PROD_W-1:0]  prod_q;
	logic [STEPS_W-1:0] mag_q;
	logic [STEPS_W-1:0] div_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               last;
	logic [STEPS_W:0]   mul_sum;
	logic [PROD_W-1:0]  mul_next;
	logic [STEPS_W:0]   trial;
	logic [STEPS_W:0]   trial_rem;
	logic               fits;
	logic [PROD_W-1:0]  div_next;

	assign last = (cnt_q == CNT_W'(STEPS_W - 1));

	// Multiply: the low half holds the multiplier and is shifted out LSB first.
	assign mul_sum  = {1'b0, prod_q[PROD_W-1:STEPS_W]} + (prod_q[0] ? {1'b0, mag_q} : '0);
	assign mul_next = {mul_sum, prod_q[STEPS_W-1:1]};

	// Divide: the high half is the remainder, the low half takes quotient bits.
	assign trial     = {prod_q[PROD_W-1:STEPS_W], prod_q[STEPS_W-1]};
	assign fits      = (trial >= {1'b0, div_q});
	assign trial_rem = fits ? (trial - {1'b0, div_q}) : trial;
	assign div_next  = {trial_rem[STEPS_W-1:0], prod_q[STEPS_W-2:0], fits};

	always_comb begin
		state_d = state_q;
		case (state_q)
			M_IDLE:  if (start) state_d = M_MUL;
			M_MUL:   if (last) state_d = M_DIV;
			M_DIV:   if (last) state_d = M_IDLE;
			default: state_d = M_IDLE;
		endcase
	end

	always_comb begin
		done = (state_q == M_DIV) && last;
		quo  = div_next[STEPS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == M_IDLE || last) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			M_IDLE: begin
				if (start) begin
					prod_q <= {{(PROD_W - STEPS_W){1'b0}}, k};
					mag_q  <= mag;
					div_q  <= divisor;
				end
			end
			M_MUL:   prod_q <= mul_next;
			M_DIV:   prod_q <= div_next;
			default: prod_q <= prod_q;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/servo_motion_interpolator_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// servo_motion_interpolator_core: multi-channel servo pulse-width ramp
// Accepts set, nudge and 20 ms tick transactions and returns the current
// pulse widths of all channels after each one.
// ----------------------------------------------------------------------------
// The block handles one command transaction at a time. A set, a nudge, a tick
// with no move in progress, and the tick that ends a move go from acceptance
// through the S_FIN state to the result register, and the next command is
// taken once the block is back in S_IDLE. A tick inside a move recomputes every
// channel through one shared bit-serial multiply-divide unit: per channel a
// start step in S_START, then eleven multiply steps and eleven divide steps
// while in S_WAIT. A waiting result transaction does not hold off the next
// command; only the load of the following result waits until the output
// register is free.
// ----------------------------------------------------------------------------
module servo_motion_interpolator_core #(
	parameter int CHANNELS = smi_pkg::CHANNELS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  smi_pkg::cmd_t cmd,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output smi_pkg::rsp_t rsp
);
	import smi_pkg::*;

	// Channels beyond the eight that the command and result can address
	// would never change nor be seen, so they are not built.
	localparam int NCH   = (CHANNELS < OUT_DUTIES) ? CHANNELS : OUT_DUTIES;
	localparam int IDX_W = (NCH > 1) ? $clog2(NCH) : 1;

	// Per-channel state. The offset is the signed distance from target to the
	// width at the start of the move.
	logic [WIDTH_W-1:0]        target_q  [NCH];
	logic [WIDTH_W-1:0]        current_q [NCH];
	logic signed [WIDTH_W-1:0] offset_q  [NCH];

	logic [STEPS_W-1:0] pend_steps_q;
	logic [STEPS_W-1:0] total_q;
	logic [STEPS_W-1:0] left_q;
	logic               pending_q;
	logic               running_q;
	logic               acc_q;
	logic [IDX_W-1:0]   idx_q;
	ctl_state_t         state_q;
	ctl_state_t         state_d;

	logic               rsp_valid_q;
	rsp_t               rsp_q;
	rsp_t               rsp_d;
	logic               rsp_load;

	logic               cmd_acc;
	logic [IDX_W-1:0]   rd_idx;
	logic [WIDTH_W-1:0] rd_target;
	logic [WIDTH_W-1:0] rd_offset;
	logic               ch_ok;
	logic [15:0]        nudge_p;
	logic [15:0]        new_p;
	logic               is_upd;
	logic               is_tick;
	logic               ok;
	logic [15:0]        t_clamp;
	logic [26:0]        set_prod;
	logic [STEPS_W-1:0] set_steps;
	logic [STEPS_W-1:0] nudge_steps;
	logic [STEPS_W-1:0] new_steps;
	logic               ramp_go;
	logic [STEPS_W-1:0] k_base;
	logic [STEPS_W-1:0] new_k;
	logic               calc_go;

	logic               md_start;
	logic               md_done;
	logic [STEPS_W-1:0] md_quo;
	logic               off_neg;
	logic [WIDTH_W-1:0] off_abs;
	logic [WIDTH_W-1:0] upd_width;
	logic               idx_last;

	logic [WIDTH_W-1:0] duty_view [OUT_DUTIES];

	assign cmd_acc = cmd_valid && !cmd_stall;

	// One read port on the target array: the addressed channel while idle,
	// the channel under computation during a ramp update.
	assign rd_idx    = (state_q == S_IDLE) ? cmd.channel[IDX_W-1:0] : idx_q;
	assign rd_target = target_q[rd_idx];
	assign rd_offset = offset_q[idx_q];

	// Command decode and validation. A nudge wraps at 16 bits before the
	// range check, so stepping below zero yields a rejected large value.
	assign ch_ok   = ({1'b0, cmd.channel} < 4'(NCH));
	assign nudge_p = cmd.direction ? ({4'b0, rd_target} + {8'b0, cmd.step})
	                               : ({4'b0, rd_target} - {8'b0, cmd.step});
	assign is_upd  = (cmd.action == ACT_SET) || (cmd.action == ACT_NUDGE);
	assign is_tick = (cmd.action == ACT_TICK);
	assign new_p   = (cmd.action == ACT_NUDGE) ? nudge_p : cmd.pulse;
	assign ok      = is_upd && ch_ok && (new_p >= PULSE_MIN) && (new_p <= PULSE_MAX);

	// The move time is kept as its count of 20 ms steps. For a set the
	// clamped time is divided by four with a shift and by five with a
	// reciprocal multiply; a nudge time of 20 * step is simply step ticks,
	// with a zero step clamped up to one tick.
	assign t_clamp     = (cmd.move_time < TIME_MIN) ? TIME_MIN :
	                     (cmd.move_time > TIME_MAX) ? TIME_MAX : cmd.move_time;
	assign set_prod    = 27'(t_clamp[14:2]) * 27'(RECIP_FIVE);
	assign set_steps   = set_prod[26:16];
	assign nudge_steps = (cmd.step == 8'd0) ? STEPS_W'(1) : STEPS_W'(cmd.step);
	assign new_steps   = (cmd.action == ACT_NUDGE) ? nudge_steps : set_steps;

	// Tick handling: a pending change starts a fresh ramp from the current
	// widths, then the remaining count drops by one. Reaching zero snaps every
	// channel to its target at once; otherwise each channel is recomputed.
	assign ramp_go = pending_q || running_q;
	assign k_base  = pending_q ? pend_steps_q : left_q;
	assign new_k   = k_base - STEPS_W'(1);
	assign calc_go = is_tick && ramp_go && (new_k != '0);

	// Width = target + trunc(offset * k / N), truncating toward zero: the
	// unit works on the magnitude and the sign is applied afterward.
	assign off_neg   = rd_offset[WIDTH_W-1];
	assign off_abs   = off_neg ? (WIDTH_W'(0) - rd_offset) : rd_offset;
	assign upd_width = off_neg ? (rd_target - {1'b0, md_quo}) : (rd_target + {1'b0, md_quo});
	assign idx_last  = (idx_q == IDX_W'(NCH - 1));

	smi_muldiv u_muldiv (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (md_start),
		.mag     (off_abs[STEPS_W-1:0]),
		.k       (left_q),
		.divisor (total_q),
		.done    (md_done),
		.quo     (md_quo)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (cmd_acc) state_d = calc_go ? S_START : S_FIN;
			S_START: state_d = S_WAIT;
			S_WAIT:  if (md_done) state_d = idx_last ? S_FIN : S_START;
			S_FIN:   if (rsp_load) state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd_stall = (state_q != S_IDLE);
		md_start  = (state_q == S_START);
		rsp_load  = (state_q == S_FIN) && (!rsp_valid_q || !rsp_stall);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < NCH; c++) begin
				target_q[c]  <= reset_width(c);
				current_q[c] <= reset_width(c);
				offset_q[c]  <= '0;
			end
			pend_steps_q <= RESET_STEPS;
			total_q      <= '0;
			left_q       <= '0;
			pending_q    <= 1'b0;
			running_q    <= 1'b0;
			acc_q        <= 1'b0;
			idx_q        <= '0;
			state_q      <= S_IDLE;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						acc_q <= ok;
						if (ok) begin
							target_q[cmd.channel[IDX_W-1:0]] <= new_p[WIDTH_W-1:0];
							pend_steps_q <= new_steps;
							pending_q    <= 1'b1;
						end
						if (is_tick && ramp_go) begin
							if (pending_q) begin
								pending_q <= 1'b0;
								total_q   <= pend_steps_q;
								for (int c = 0; c < NCH; c++) begin
									offset_q[c] <= current_q[c] - target_q[c];
								end
							end
							left_q <= new_k;
							idx_q  <= '0;
							if (new_k == '0) begin
								running_q <= 1'b0;
								for (int c = 0; c < NCH; c++) begin
									current_q[c] <= target_q[c];
								end
							end else begin
								running_q <= 1'b1;
							end
						end
					end
				end
				S_WAIT: begin
					if (md_done) begin
						current_q[idx_q] <= upd_width;
						idx_q            <= idx_q + IDX_W'(1);
					end
				end
				S_START, S_FIN: begin
				end
			endcase
		end
	end

	for (genvar g = 0; g < OUT_DUTIES; g++) begin : g_duty
		if (g < NCH) begin : g_on
			assign duty_view[g] = current_q[g];
		end else begin : g_off
			assign duty_view[g] = '0;
		end
	end

	assign rsp_d = '{
		duty_0:   duty_view[0],
		duty_1:   duty_view[1],
		duty_2:   duty_view[2],
		duty_3:   duty_view[3],
		duty_4:   duty_view[4],
		duty_5:   duty_view[5],
		duty_6:   duty_view[6],
		duty_7:   duty_view[7],
		moving:   running_q,
		accepted: acc_q
	};

	// Result register: holds a transaction until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= rsp_load || (rsp_valid_q && rsp_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

// ===== rtl/smi_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// smi_checker: port-level checks for the servo motion interpolator
// Watches the command and result channels of the top level.
// ----------------------------------------------------------------------------
module smi_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          cmd_valid,
	input logic          cmd_stall,
	input smi_pkg::cmd_t cmd,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input smi_pkg::rsp_t rsp
);
	import smi_pkg::*;

	// The block works on one command at a time, so it is busy right after
	// taking one.
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> cmd_stall)
		else $error("command accepted while the previous one was in progress");

	// Every reported width stays at or below the top of the legal pulse range.
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp.duty_0 <= PULSE_MAX[WIDTH_W-1:0]) &&
		              (rsp.duty_1 <= PULSE_MAX[WIDTH_W-1:0]) &&
		              (rsp.duty_2 <= PULSE_MAX[WIDTH_W-1:0]) &&
		              (rsp.duty_3 <= PULSE_MAX[WIDTH_W-1:0]) &&
		              (rsp.duty_4 <= PULSE_MAX[WIDTH_W-1:0]) &&
		              (rsp.duty_5 <= PULSE_MAX[WIDTH_W-1:0]) &&
		              (rsp.duty_6 <= PULSE_MAX[WIDTH_W-1:0]) &&
		              (rsp.duty_7 <= PULSE_MAX[WIDTH_W-1:0]))
		else $error("reported pulse width out of range");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
		else $error("stalled result transaction changed or dropped");

endmodule

bind servo_motion_interpolator_core smi_checker u_smi_checker (.*);
`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the servo motion interpolator core
// Drives set, nudge and tick transactions through the command channel, keeps
// its own model of the eight servo ramps, and checks every returned pulse-width
// report field by field while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

	import smi_pkg::*;

	// The command encoding leaves one code unused; the block must ignore it.
	localparam logic [1:0] ACT_SPARE = 2'd3;
	// A move tick is 20 ms; the move time divided by this gives the step count.
	localparam int TICK_MS = 20;
	// Longest internal latency of one transaction (a tick inside a move), with margin.
	localparam int SETTLE_CYCLES = 400;
	// Length of the long receiver hold-off that backs the block up.
	localparam int HOLD_CYCLES = 600;

	typedef struct {
		cmd_t stim;
		bit   typed;
		rsp_t want;
	} plan_row_t;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  cmd_valid = 1'b0;
	logic  cmd_stall;
	cmd_t  cmd       = '0;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	rsp_t  rsp;

	servo_motion_interpolator_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Ramp predictor. It mirrors the block's architectural state: the target
	// and present pulse width of every channel, the offset latched at the start
	// of a move, the shared move time, and the step counters of the ramp.
	// ------------------------------------------------------------------------
	logic [11:0] tgt_w [8];
	logic [11:0] cur_w [8];
	int          start_off [8];
	logic [14:0] move_ms;
	logic [10:0] n_steps;
	logic [10:0] k_left;
	bit          pending;
	bit          ramping;

	// Reports still owed by the block, oldest first.
	rsp_t duty_reports_q [$];

	int fails     = 0;
	int send_gap_pct = 0;
	int rcv_gap_pct  = 0;
	int hold_req  = 0;
	int hold_done = 0;
	int hold_left = 0;

	function automatic void clear_servos();
		for (int c = 0; c < 8; c++) begin
			case (c)
				3:       tgt_w[c] = 12'd1050;
				4:       tgt_w[c] = 12'd1000;
				5:       tgt_w[c] = 12'd1700;
				default: tgt_w[c] = 12'd1500;
			endcase
			cur_w[c]     = tgt_w[c];
			start_off[c] = 0;
		end
		move_ms = 15'd2000;
		n_steps = '0;
		k_left  = '0;
		pending = 1'b0;
		ramping = 1'b0;
	endfunction

	// A new target is only taken when the pulse lies in the servo's legal
	// window; the move time is clamped rather than rejected.
	function automatic bit take_target(input int unsigned ch, input int unsigned p,
			input int unsigned t);
		if (p < PULSE_MIN || p > PULSE_MAX)
			return 1'b0;
		if (t < TIME_MIN)
			t = TIME_MIN;
		if (t > TIME_MAX)
			t = TIME_MAX;
		tgt_w[ch] = p[11:0];
		move_ms   = t[14:0];
		pending   = 1'b1;
		return 1'b1;
	endfunction

	// One 20 ms tick. A pending change restarts the ramp from the present
	// widths; the tick that brings the count to zero lands on the targets.
	function automatic void advance_ramp();
		int lin;
		int n;
		if (pending) begin
			pending = 1'b0;
			n_steps = 11'(int'(move_ms) / TICK_MS);
			if (n_steps == 0)
				n_steps = 11'd1;
			for (int c = 0; c < 8; c++)
				start_off[c] = int'(cur_w[c]) - int'(tgt_w[c]);
			k_left  = n_steps;
			ramping = 1'b1;
		end
		if (ramping) begin
			k_left = k_left - 11'd1;
			n      = int'(n_steps);
			for (int c = 0; c < 8; c++) begin
				if (k_left == 0) begin
					cur_w[c] = tgt_w[c];
				end else begin
					// Signed division in SystemVerilog truncates toward zero.
					lin      = int'(tgt_w[c]) + (start_off[c] * int'(k_left)) / n;
					cur_w[c] = lin[11:0];
				end
			end
			if (k_left == 0)
				ramping = 1'b0;
		end
	endfunction

	function automatic rsp_t predict_duties(input cmd_t c);
		rsp_t        r;
		bit          ok;
		int unsigned base;
		int unsigned p;
		ok = 1'b0;
		case (c.action)
			ACT_SET: begin
				ok = take_target(c.channel, c.pulse, c.move_time);
			end
			ACT_NUDGE: begin
				base = tgt_w[c.channel];
				p    = c.direction ? base + c.step : base - c.step;
				ok   = take_target(c.channel, p & 32'hFFFF, TICK_MS * c.step);
			end
			ACT_TICK: begin
				advance_ramp();
			end
			default: ;
		endcase
		r.duty_0   = cur_w[0];
		r.duty_1   = cur_w[1];
		r.duty_2   = cur_w[2];
		r.duty_3   = cur_w[3];
		r.duty_4   = cur_w[4];
		r.duty_5   = cur_w[5];
		r.duty_6   = cur_w[6];
		r.duty_7   = cur_w[7];
		r.moving   = ramping;
		r.accepted = ok;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Command side. Every call starts and ends at a falling edge, so valid and
	// the payload get at most one update per time step. Acceptance is judged
	// on the stall value seen at the rising edge, before the block updates it.
	// ------------------------------------------------------------------------
	task automatic offer(input cmd_t c, input bit typed, input rsp_t want);
		rsp_t guess;
		while ($urandom_range(99) < send_gap_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		// The predictor always advances; a typed row only swaps in its own value.
		guess = predict_duties(c);
		duty_reports_q.push_back(typed ? want : guess);
		@(negedge clk);
	endtask

	task automatic issue(input cmd_t c);
		offer(c, 1'b0, '0);
	endtask

	// Take the command channel idle and wait until every report has come back.
	task automatic drain();
		cmd_valid <= 1'b0;
		while (duty_reports_q.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic cmd_t mk(input logic [1:0] act, input int unsigned ch,
			input int unsigned p, input int unsigned t, input bit dir, input int unsigned st);
		cmd_t c;
		c.action    = act;
		c.channel   = ch[2:0];
		c.pulse     = p[15:0];
		c.move_time = t[15:0];
		c.direction = dir;
		c.step      = st[7:0];
		return c;
	endfunction

	// A set or nudge with random content. Most pulses are legal and most move
	// times short, so that ramps run to their end within a few dozen ticks.
	function automatic cmd_t make_setpoint();
		cmd_t        c;
		logic [63:0] r;
		r = {$urandom, $urandom};
		c = r[$bits(cmd_t)-1:0];
		if ($urandom_range(1)) begin
			c.action = ACT_SET;
			case ($urandom_range(19))
				0:       c.pulse = $urandom_range(65535);
				1:       c.pulse = $urandom_range(499);
				2:       c.pulse = $urandom_range(2501, 2600);
				3:       c.pulse = $urandom_range(1) ? PULSE_MIN : PULSE_MAX;
				default: c.pulse = $urandom_range(PULSE_MIN, PULSE_MAX);
			endcase
			case ($urandom_range(9))
				6, 7:    c.move_time = $urandom_range(400, 2000);
				8:       c.move_time = $urandom_range(2000, 30000);
				9:       c.move_time = $urandom_range(65535);
				default: c.move_time = $urandom_range(400);
			endcase
		end else begin
			c.action = ACT_NUDGE;
			if ($urandom_range(9) < 7)
				c.step = $urandom_range(20);
		end
		return c;
	endfunction

	// Well-formed moves: a few target changes followed by enough ticks to
	// finish the ramp, or, now and then, too few so that the next change
	// lands in the middle of it. About one item in ten is raw noise.
	task automatic run_moves(input int quota);
		int          sent;
		int          n_cmds;
		int          n_ticks;
		int          ramp_n;
		cmd_t        c;
		logic [63:0] r;
		sent = 0;
		while (sent < quota) begin
			if ($urandom_range(9) == 0) begin
				r = {$urandom, $urandom};
				c = r[$bits(cmd_t)-1:0];
				issue(c);
				if (c.action != ACT_SPARE)
					sent++;
			end else begin
				n_cmds = $urandom_range(1, 4);
				repeat (n_cmds) begin
					issue(make_setpoint());
					sent++;
				end
				ramp_n = pending ? int'(move_ms) / TICK_MS : int'(k_left);
				if (ramp_n < 1)
					ramp_n = 1;
				if ($urandom_range(3) == 0)
					n_ticks = $urandom_range(1, ramp_n);
				else
					n_ticks = ramp_n + $urandom_range(1, 2);
				if (n_ticks > 40)
					n_ticks = $urandom_range(20, 40);
				repeat (n_ticks) begin
					issue(mk(ACT_TICK, $urandom_range(7), $urandom_range(65535),
						$urandom_range(65535), $urandom_range(1), $urandom_range(255)));
					sent++;
				end
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Result side. The receiver stalls at random, except while a requested
	// hold-off is counting down; then it stalls solidly so that the output
	// register stays full and the block must push back on its command input.
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (hold_req != hold_done) begin
			hold_done = hold_req;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < rcv_gap_pct);
		end
	end

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (duty_reports_q.size() == 0) begin
				$error("unexpected report transaction: no command outstanding");
				fails++;
			end else begin
				want = duty_reports_q.pop_front();
				check_field("duty_0", want.duty_0, rsp.duty_0);
				check_field("duty_1", want.duty_1, rsp.duty_1);
				check_field("duty_2", want.duty_2, rsp.duty_2);
				check_field("duty_3", want.duty_3, rsp.duty_3);
				check_field("duty_4", want.duty_4, rsp.duty_4);
				check_field("duty_5", want.duty_5, rsp.duty_5);
				check_field("duty_6", want.duty_6, rsp.duty_6);
				check_field("duty_7", want.duty_7, rsp.duty_7);
				check_field("moving", want.moving, rsp.moving);
				check_field("accepted", want.accepted, rsp.accepted);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------
	initial begin
		plan_row_t plan [$];
		rsp_t      home_rej;
		rsp_t      home_acc;
		rsp_t      ch0_done;

		clear_servos();

		// Reset pose of the arm; nothing has moved and nothing was accepted.
		home_rej = '{duty_0: 12'd1500, duty_1: 12'd1500, duty_2: 12'd1500,
			duty_3: 12'd1050, duty_4: 12'd1000, duty_5: 12'd1700,
			duty_6: 12'd1500, duty_7: 12'd1500, moving: 1'b0, accepted: 1'b0};
		home_acc          = home_rej;
		home_acc.accepted = 1'b1;
		ch0_done          = home_rej;
		ch0_done.duty_0   = 12'd500;

		// Directed rows. The first few have their reports written out by hand:
		// a tick with nothing pending, pulses just outside and far outside the
		// legal window, the unused action code with every bit set, and a set at
		// the low pulse limit whose zero move time clamps to one step, so the
		// very next tick finishes the move and leaves moving low.
		plan.push_back('{mk(ACT_TICK, 0, 0, 0, 0, 0), 1'b1, home_rej});
		plan.push_back('{mk(ACT_SET, 0, 499, 1000, 0, 0), 1'b1, home_rej});
		plan.push_back('{mk(ACT_SET, 0, 2501, 1000, 0, 0), 1'b1, home_rej});
		plan.push_back('{mk(ACT_SET, 7, 16'hFFFF, 16'hFFFF, 1, 255), 1'b1, home_rej});
		plan.push_back('{mk(ACT_SPARE, 7, 16'hFFFF, 16'hFFFF, 1, 255), 1'b1, home_rej});
		plan.push_back('{mk(ACT_SET, 0, 500, 0, 0, 0), 1'b1, home_acc});
		plan.push_back('{mk(ACT_TICK, 0, 0, 0, 0, 0), 1'b1, ch0_done});
		// Top pulse with the longest move time, which clamps to 30 s.
		plan.push_back('{mk(ACT_SET, 1, 2500, 16'hFFFF, 0, 0), 1'b0, '0});
		plan.push_back('{mk(ACT_TICK, 0, 0, 0, 0, 0), 1'b0, '0});
		plan.push_back('{mk(ACT_TICK, 0, 0, 0, 0, 0), 1'b0, '0});
		// Changes in the middle of that move: the largest upward nudge, a
		// downward nudge that falls below the window, and a zero-step nudge.
		plan.push_back('{mk(ACT_NUDGE, 2, 0, 0, 1, 255), 1'b0, '0});
		plan.push_back('{mk(ACT_NUDGE, 0, 0, 0, 0, 255), 1'b0, '0});
		plan.push_back('{mk(ACT_NUDGE, 3, 0, 0, 0, 0), 1'b0, '0});
		plan.push_back('{mk(ACT_TICK, 0, 0, 0, 0, 0), 1'b0, '0});
		plan.push_back('{mk(ACT_NUDGE, 4, 0, 0, 1, 1), 1'b0, '0});
		plan.push_back('{mk(ACT_SET, 5, 2500, 20, 0, 0), 1'b0, '0});
		// A nudge that pushes past the top of the window is refused.
		plan.push_back('{mk(ACT_NUDGE, 5, 0, 0, 1, 1), 1'b0, '0});
		// A two-step ramp run to its end, then a tick with nothing to do.
		plan.push_back('{mk(ACT_SET, 6, 1234, 40, 0, 0), 1'b0, '0});
		plan.push_back('{mk(ACT_TICK, 0, 0, 0, 0, 0), 1'b0, '0});
		plan.push_back('{mk(ACT_TICK, 0, 0, 0, 0, 0), 1'b0, '0});
		plan.push_back('{mk(ACT_TICK, 0, 0, 0, 0, 0), 1'b0, '0});
		plan.push_back('{mk(ACT_NUDGE, 7, 0, 0, 1, 255), 1'b0, '0});

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// First phase: the sender idles a little, the receiver a lot.
		send_gap_pct = 16;
		rcv_gap_pct  = 55;
		foreach (plan[i])
			offer(plan[i].stim, plan[i].typed, plan[i].want);
		run_moves(260);

		// Ask the receiver for a long hold-off while commands keep coming, so
		// that the block backs up and stalls its command input.
		@(posedge clk);
		hold_req++;
		@(negedge clk);
		run_moves(270);

		// The sender pauses here until every report has been collected.
		drain();

		// Second phase: the roles swap.
		send_gap_pct = 55;
		rcv_gap_pct  = 16;
		run_moves(530);
		drain();

		// Last phase: back-to-back traffic on both sides.
		send_gap_pct = 0;
		rcv_gap_pct  = 0;
		run_moves(530);
		drain();

		// Anything the block still emits now has no command behind it.
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fails == 0 && duty_reports_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#8000000;
		$display("FAIL");
		$finish;
	end

endmodule
`default_nettype wire
